// ----- rtl/lmps_pkg.sv -----
// lmps_pkg: shared types and constants of the led matrix pixel store
`timescale 1ns / 1ps
`default_nettype none

package lmps_pkg;

  // matrix limits and derived store geometry
  localparam int MAX_WIDTH   = 64;
  localparam int MAX_HEIGHT  = 64;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int IDX_W       = $clog2(STORE_DEPTH);

  // fixed field widths
  localparam int DIM_W    = 7;
  localparam int COORD_W  = 6;
  localparam int LAYOUT_W = 4;
  localparam int COLOR_W  = 24;
  localparam int MASK_W   = 3;
  localparam int CFG_IDX_W = 2;

  // command codes
  typedef enum logic [1:0] {
    CMD_WRITE      = 2'd0,
    CMD_READ_XY    = 2'd1,
    CMD_READ_CHAIN = 2'd2,
    CMD_CLEAR      = 2'd3
  } cmd_e;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT = 2'd2;

  // address generation result
  typedef struct packed {
    logic [IDX_W-1:0] idx;   // store address for the command
    logic [IDX_W-1:0] last;  // last entry of the active matrix
    logic             oor;   // coordinate or chain position outside the matrix
  } map_res_t;

endpackage

`default_nettype wire

// ----- rtl/lmps_if.sv -----
// lmps_if: valid/ready channel interfaces for request, response and config
`timescale 1ns / 1ps
`default_nettype none

interface lmps_req_if;
  logic                                valid;
  logic                                ready;
  lmps_pkg::cmd_e                      cmd;
  logic [lmps_pkg::COORD_W-1:0]        row;
  logic [lmps_pkg::COORD_W-1:0]        col;
  logic [lmps_pkg::IDX_W-1:0]          chain_pos;
  logic [lmps_pkg::COLOR_W-1:0]        color_in;
  logic [lmps_pkg::MASK_W-1:0]         byte_mask;

  modport source (output valid, cmd, row, col, chain_pos, color_in, byte_mask,
                  input ready);
  modport sink   (input valid, cmd, row, col, chain_pos, color_in, byte_mask,
                  output ready);
endinterface

interface lmps_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [lmps_pkg::COLOR_W-1:0] read_data;
  logic                         status;

  modport source (output valid, read_data, status, input ready);
  modport sink   (input valid, read_data, status, output ready);
endinterface

interface lmps_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lmps_pkg::CFG_IDX_W-1:0] index;
  logic [lmps_pkg::DIM_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/lmps_ram.sv -----
// lmps_ram: generic single-write, single-read ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module lmps_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds while idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lmps_map.sv -----
// lmps_map: coordinate to chain position mapping and range checks
`timescale 1ns / 1ps
`default_nettype none

module lmps_map (
  input  lmps_pkg::cmd_e                   cmd_i,
  input  wire logic [lmps_pkg::COORD_W-1:0]  row_i,
  input  wire logic [lmps_pkg::COORD_W-1:0]  col_i,
  input  wire logic [lmps_pkg::IDX_W-1:0]    pos_i,
  input  wire logic [lmps_pkg::DIM_W-1:0]    width_i,
  input  wire logic [lmps_pkg::DIM_W-1:0]    height_i,
  input  wire logic [lmps_pkg::LAYOUT_W-1:0] layout_i,
  output lmps_pkg::map_res_t               res_o
);
  import lmps_pkg::*;

  logic [DIM_W-1:0]     w, h;
  logic [COORD_W-1:0]   ri, rj;
  logic [COORD_W-1:0]   major, minor;
  logic [DIM_W-1:0]     stride;
  logic [2*DIM_W-1:0]   total;
  logic [2*DIM_W-1:0]   lin;
  logic                 w_par, h_par;
  logic                 xy_oor, pos_oor;

  // clamp the size registers to 1..max
  always_comb begin
    if (width_i == '0)                         w = DIM_W'(1);
    else if (width_i > DIM_W'(MAX_WIDTH))      w = DIM_W'(MAX_WIDTH);
    else                                       w = width_i;
    if (height_i == '0)                        h = DIM_W'(1);
    else if (height_i > DIM_W'(MAX_HEIGHT))    h = DIM_W'(MAX_HEIGHT);
    else                                       h = height_i;
  end

  // mirrored coordinates and far-edge parities
  assign ri    = COORD_W'(h - DIM_W'(1) - {1'b0, row_i});
  assign rj    = COORD_W'(w - DIM_W'(1) - {1'b0, col_i});
  assign w_par = w[0] ^ col_i[0];
  assign h_par = h[0] ^ row_i[0];

  // layout select: bit 2 picks row-major strides
  always_comb begin
    unique case (layout_i)
      4'd0:  begin major = col_i; minor = col_i[0] ? ri : row_i; end
      4'd1:  begin major = col_i; minor = row_i; end
      4'd2:  begin major = rj;    minor = w_par ? row_i : ri; end
      4'd3:  begin major = rj;    minor = row_i; end
      4'd4:  begin major = row_i; minor = row_i[0] ? rj : col_i; end
      4'd5:  begin major = row_i; minor = col_i; end
      4'd6:  begin major = row_i; minor = row_i[0] ? col_i : rj; end
      4'd7:  begin major = row_i; minor = rj; end
      4'd8:  begin major = col_i; minor = col_i[0] ? row_i : ri; end
      4'd9:  begin major = col_i; minor = ri; end
      4'd10: begin major = rj;    minor = w_par ? ri : row_i; end
      4'd11: begin major = rj;    minor = ri; end
      4'd12: begin major = ri;    minor = h_par ? col_i : rj; end
      4'd13: begin major = ri;    minor = col_i; end
      4'd14: begin major = ri;    minor = h_par ? rj : col_i; end
      default: begin major = ri;  minor = rj; end
    endcase
    stride = layout_i[2] ? w : h;
  end

  assign lin   = ({{(2*DIM_W-COORD_W){1'b0}}, major} * {{DIM_W{1'b0}}, stride})
               + {{(2*DIM_W-COORD_W){1'b0}}, minor};
  assign total = {{DIM_W{1'b0}}, w} * {{DIM_W{1'b0}}, h};

  // range checks
  assign xy_oor  = ({1'b0, row_i} >= h) || ({1'b0, col_i} >= w);
  assign pos_oor = {{(2*DIM_W-IDX_W){1'b0}}, pos_i} >= total;

  always_comb begin
    res_o.last = IDX_W'(total - (2*DIM_W)'(1));
    unique case (cmd_i)
      CMD_WRITE, CMD_READ_XY: begin
        res_o.idx = IDX_W'(lin);
        res_o.oor = xy_oor;
      end
      CMD_READ_CHAIN: begin
        res_o.idx = pos_i;
        res_o.oor = pos_oor;
      end
      default: begin
        res_o.idx = '0;
        res_o.oor = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/led_matrix_pixel_store_core.sv -----
// led_matrix_pixel_store_core: top level of the led matrix pixel store
//
//   channel  dir  payload                                        accepted on
//   req_i    in   cmd, row, col, chain_pos, color_in, byte_mask  valid && ready
//   rsp_o    out  read_data, status                              valid && ready
//   cfg_i    in   index, data (width, height, layout)            valid && ready
//
// a pixel write or read passes through accept, address map and ram read,
// ram data and write-back, deliver; the response comes from registers. an
// access off the matrix skips the ram and goes from address map to deliver.
// a clear walks the width*height entries of the store one entry per cycle.
// after reset the store is zeroed by a pass over all 4096 entries, during
// which req_i.ready is low; config writes are always taken.
// a waiting response does not block the next request; a result stalls only
// if the previous response is still not taken.
`timescale 1ns / 1ps
`default_nettype none

module led_matrix_pixel_store_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lmps_req_if.sink   req_i,
  lmps_rsp_if.source rsp_o,
  lmps_cfg_if.sink   cfg_i
);
  import lmps_pkg::*;

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_MAP    = 3'd2;
  localparam logic [2:0] ST_ACCESS = 3'd3;
  localparam logic [2:0] ST_CLEAR  = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0]          state_q, state_d;
  cmd_e                cmd_q;
  logic [COORD_W-1:0]  row_q, col_q;
  logic [IDX_W-1:0]    pos_q;
  logic [COLOR_W-1:0]  color_q;
  logic [MASK_W-1:0]   mask_q;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [IDX_W-1:0]    clr_cnt_q, clr_cnt_d;
  logic [IDX_W-1:0]    clr_last_q, clr_last_d;
  logic [COLOR_W-1:0]  res_data_q, res_data_d;
  logic                res_stat_q, res_stat_d;
  logic                out_valid_q, out_valid_d;
  logic [COLOR_W-1:0]  out_data_q;
  logic                out_stat_q;
  logic                out_load;
  logic [DIM_W-1:0]    width_q, height_q;
  logic [LAYOUT_W-1:0] layout_q;

  map_res_t            map_res;
  logic                ram_we, ram_re;
  logic [IDX_W-1:0]    ram_waddr;
  logic [COLOR_W-1:0]  ram_wdata, ram_rdata;
  logic [COLOR_W-1:0]  bit_mask;
  logic                req_fire;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(1);
      height_q <= DIM_W'(1);
      layout_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_WIDTH:  width_q  <= cfg_i.data;
        CFG_HEIGHT: height_q <= cfg_i.data;
        CFG_LAYOUT: layout_q <= cfg_i.data[LAYOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      cmd_q   <= req_i.cmd;
      row_q   <= req_i.row;
      col_q   <= req_i.col;
      pos_q   <= req_i.chain_pos;
      color_q <= req_i.color_in;
      mask_q  <= req_i.byte_mask;
    end
  end

  lmps_map u_map (
    .cmd_i    (cmd_q),
    .row_i    (row_q),
    .col_i    (col_q),
    .pos_i    (pos_q),
    .width_i  (width_q),
    .height_i (height_q),
    .layout_i (layout_q),
    .res_o    (map_res)
  );

  assign bit_mask = {{8{mask_q[2]}}, {8{mask_q[1]}}, {8{mask_q[0]}}};

  // sequencer: map, read, modify-write, clear walk
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    clr_cnt_d  = clr_cnt_q;
    clr_last_d = clr_last_q;
    res_data_d = res_data_q;
    res_stat_d = res_stat_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = idx_q;
    ram_wdata  = (ram_rdata & ~bit_mask) | (color_q & bit_mask);
    out_load   = 1'b0;
    unique case (state_q)
      ST_INIT, ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
        clr_cnt_d = clr_cnt_q + IDX_W'(1);
        if (clr_cnt_q == clr_last_q) begin
          res_data_d = '0;
          res_stat_d = 1'b0;
          state_d    = (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
        end
      end
      ST_IDLE: begin
        if (req_fire) state_d = ST_MAP;
      end
      ST_MAP: begin
        if (cmd_q == CMD_CLEAR) begin
          clr_cnt_d  = '0;
          clr_last_d = map_res.last;
          state_d    = ST_CLEAR;
        end else if (map_res.oor) begin
          res_data_d = '0;
          res_stat_d = 1'b1;
          state_d    = ST_DONE;
        end else begin
          ram_re  = 1'b1;
          idx_d   = map_res.idx;
          state_d = ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        res_stat_d = 1'b0;
        unique case (cmd_q)
          CMD_WRITE: begin
            ram_we     = 1'b1;
            res_data_d = '0;
          end
          CMD_READ_XY:    res_data_d = ram_rdata;
          CMD_READ_CHAIN: res_data_d = {ram_rdata[7:0], ram_rdata[15:8], ram_rdata[23:16]};
          default:        res_data_d = '0;
        endcase
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !rsp_o.ready);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      clr_cnt_q   <= '0;
      clr_last_q  <= IDX_W'(STORE_DEPTH - 1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      clr_last_q  <= clr_last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    res_data_q <= res_data_d;
    res_stat_q <= res_stat_d;
    if (out_load) begin
      out_data_q <= res_data_q;
      out_stat_q <= res_stat_q;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.read_data = out_data_q;
  assign rsp_o.status    = out_stat_q;

  lmps_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (map_res.idx),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire
